@@ rtl/core/ghs_pkg.sv @@
// shared types, widths and codes for the grow/hold/shrink overlay timer
package ghs_pkg;

    // field widths
    localparam int unsigned POS_W   = 12;
    localparam int unsigned SIZE_W  = 10;
    localparam int unsigned TICKS_W = 16;
    localparam int unsigned TIMER_W = 18;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned CDATA_W = 16;

    // product of a scale and a full size, as built by the serial multiplier
    localparam int unsigned ACC_W = TICKS_W + SIZE_W;

    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    // item modes
    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_START   = 2'd2;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [CIDX_W-1:0] REG_ORIGIN_Y     = 3'd1;
    localparam logic [CIDX_W-1:0] REG_FULL_WIDTH   = 3'd2;
    localparam logic [CIDX_W-1:0] REG_FULL_HEIGHT  = 3'd3;
    localparam logic [CIDX_W-1:0] REG_GROW_TICKS   = 3'd4;
    localparam logic [CIDX_W-1:0] REG_HOLD_TICKS   = 3'd5;
    localparam logic [CIDX_W-1:0] REG_SHRINK_TICKS = 3'd6;
    localparam logic [CIDX_W-1:0] REG_BLINK_ENABLE = 3'd7;

    // input item
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [TICKS_W-1:0] advance_amount;
    } ghs_cmd_t;

    // result item
    typedef struct packed {
        logic [SIZE_W-1:0]        out_width;
        logic [SIZE_W-1:0]        out_height;
        logic signed [POS_W-1:0]  out_x;
        logic signed [POS_W-1:0]  out_y;
        logic                     hidden;
        logic                     active;
        logic [TIMER_W-1:0]       timer_value;
    } ghs_res_t;

    // live configuration plus the phase boundaries derived from it
    typedef struct packed {
        logic signed [POS_W-1:0] origin_x;
        logic signed [POS_W-1:0] origin_y;
        logic [SIZE_W-1:0]       full_width;
        logic [SIZE_W-1:0]       full_height;
        logic [TICKS_W-1:0]      grow;
        logic [TICKS_W-1:0]      hold;
        logic [TICKS_W-1:0]      shrink;
        logic                    blink;
        logic [TICKS_W:0]        grow_hold;
        logic [TIMER_W-1:0]      total;
    } ghs_cfg_t;

endpackage

@@ rtl/core/ghs_cfg_regs.sv @@
// configuration registers and phase boundary sums
module ghs_cfg_regs
    import ghs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CDATA_W-1:0] cfg_data,
    output ghs_cfg_t           cfg
);

    logic signed [POS_W-1:0] origin_x_reg;
    logic signed [POS_W-1:0] origin_y_reg;
    logic [SIZE_W-1:0]       full_width_reg;
    logic [SIZE_W-1:0]       full_height_reg;
    logic [TICKS_W-1:0]      grow_reg;
    logic [TICKS_W-1:0]      hold_reg;
    logic [TICKS_W-1:0]      shrink_reg;
    logic                    blink_reg;

    // register writes, a zero grow length is stored as one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            full_width_reg  <= '0;
            full_height_reg <= '0;
            grow_reg        <= TICKS_W'(1);
            hold_reg        <= '0;
            shrink_reg      <= '0;
            blink_reg       <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X:     origin_x_reg    <= cfg_data[POS_W-1:0];
                REG_ORIGIN_Y:     origin_y_reg    <= cfg_data[POS_W-1:0];
                REG_FULL_WIDTH:   full_width_reg  <= cfg_data[SIZE_W-1:0];
                REG_FULL_HEIGHT:  full_height_reg <= cfg_data[SIZE_W-1:0];
                REG_GROW_TICKS:   grow_reg        <= (cfg_data == '0) ? TICKS_W'(1)
                                                                     : cfg_data[TICKS_W-1:0];
                REG_HOLD_TICKS:   hold_reg        <= cfg_data[TICKS_W-1:0];
                REG_SHRINK_TICKS: shrink_reg      <= cfg_data[TICKS_W-1:0];
                REG_BLINK_ENABLE: blink_reg       <= cfg_data[0];
                default:          blink_reg       <= blink_reg;
            endcase
        end
    end

    // phase boundaries
    always_comb
    begin
        cfg.origin_x    = origin_x_reg;
        cfg.origin_y    = origin_y_reg;
        cfg.full_width  = full_width_reg;
        cfg.full_height = full_height_reg;
        cfg.grow        = grow_reg;
        cfg.hold        = hold_reg;
        cfg.shrink      = shrink_reg;
        cfg.blink       = blink_reg;
        cfg.grow_hold   = {1'b0, grow_reg} + {1'b0, hold_reg};
        cfg.total       = {1'b0, cfg.grow_hold} + TIMER_W'(shrink_reg);
    end

endmodule

@@ rtl/core/ghs_muldiv.sv @@
// bit-serial scale unit: size * scale / divisor, multiply then restoring divide
module ghs_muldiv
    import ghs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [TICKS_W-1:0] scale,
    input  logic [TICKS_W-1:0] divisor,
    input  logic [SIZE_W-1:0]  full,
    output logic               done,
    output logic [SIZE_W-1:0]  quotient
);

    localparam int unsigned CNT_W = $clog2(SIZE_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SIZE_W - 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_MUL,
        PH_DIV
    } phase_t;

    phase_t             phase_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               done_reg;

    logic [TICKS_W-1:0] scale_reg;
    logic [TICKS_W-1:0] div_reg;
    logic [SIZE_W-1:0]  mult_sr_reg;
    logic [ACC_W-1:0]   acc_reg;

    logic [ACC_W-1:0]   acc_mul_next;
    logic [ACC_W-1:0]   acc_div_next;
    logic [TICKS_W:0]   rem_shift;
    logic [TICKS_W:0]   rem_diff;
    logic               rem_ge;
    logic [TICKS_W-1:0] rem_new;

    // multiply step: msb-first shift and add of the scale
    assign acc_mul_next = {acc_reg[ACC_W-2:0], 1'b0}
                        + (mult_sr_reg[SIZE_W-1] ? ACC_W'(scale_reg) : '0);

    // divide step: remainder in the upper bits, quotient shifts in at the bottom
    assign rem_shift = {acc_reg[ACC_W-1:SIZE_W], acc_reg[SIZE_W-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign rem_ge    = (rem_shift >= {1'b0, div_reg});
    assign rem_new   = rem_ge ? rem_diff[TICKS_W-1:0] : rem_shift[TICKS_W-1:0];
    assign acc_div_next = {rem_new, acc_reg[SIZE_W-2:0], rem_ge};

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (phase_reg == PH_DIV) && (cnt_reg == LAST_STEP);
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (start)
                    begin
                        phase_reg <= PH_MUL;
                        cnt_reg   <= '0;
                    end
                end
                PH_MUL:
                begin
                    if (cnt_reg == LAST_STEP)
                    begin
                        phase_reg <= PH_DIV;
                        cnt_reg   <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                PH_DIV:
                begin
                    if (cnt_reg == LAST_STEP)
                    begin
                        phase_reg <= PH_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    // datapath shift registers
    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_IDLE && start)
        begin
            scale_reg   <= scale;
            div_reg     <= divisor;
            mult_sr_reg <= full;
            acc_reg     <= '0;
        end
        else if (phase_reg == PH_MUL)
        begin
            acc_reg     <= acc_mul_next;
            mult_sr_reg <= {mult_sr_reg[SIZE_W-2:0], 1'b0};
        end
        else if (phase_reg == PH_DIV)
        begin
            acc_reg <= acc_div_next;
        end
    end

    assign done     = done_reg;
    assign quotient = acc_reg[SIZE_W-1:0];

endmodule

@@ rtl/core/grow_hold_shrink_overlay_timer_unit.sv @@
// Overlay timer top level: timer control, geometry lanes and result register.
// Tick items on a running timer pass through S_CALC, then S_DONE, and commit into the result register;
// the two bit-serial lanes run 10 multiply and 10 divide steps each, one bit per cycle.
// Start, advance and idle items skip S_CALC; no item is accepted until the previous one commits.
// A new item is accepted while an earlier result still waits in the output register.
// Asynchronous active-low reset clears the timer, geometry and configuration (grow length 1).
module grow_hold_shrink_overlay_timer_unit
    import ghs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  ghs_cmd_t           cmd,
    output logic               res_valid,
    input  logic               res_stall,
    output ghs_res_t           res,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CDATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_START,
        OP_STOP,
        OP_TICK,
        OP_ADVANCE
    } op_t;

    ghs_cfg_t cfg;

    state_t                  state_reg;
    op_t                     op_reg;
    op_t                     op_next;
    logic [TICKS_W-1:0]      amount_reg;
    logic                    blink_upd_reg;
    logic                    blink_val_reg;

    logic [TIMER_W-1:0]      tick_reg;
    logic [TIMER_W-1:0]      tick_next;
    logic                    running_reg;
    logic                    running_next;
    logic                    blank_reg;
    logic                    blank_next;
    logic [SIZE_W-1:0]       width_reg;
    logic [SIZE_W-1:0]       width_next;
    logic [SIZE_W-1:0]       height_reg;
    logic [SIZE_W-1:0]       height_next;
    logic signed [POS_W-1:0] x_reg;
    logic signed [POS_W-1:0] x_next;
    logic signed [POS_W-1:0] y_reg;
    logic signed [POS_W-1:0] y_next;

    logic                    res_valid_reg;
    ghs_res_t                res_reg;

    logic                    accept;
    logic                    commit;
    logic                    in_grow_hold;
    logic                    lane_start;
    logic [TICKS_W-1:0]      lane_scale;
    logic [TICKS_W-1:0]      lane_div;
    logic                    lane_w_done;
    logic                    lane_h_done;
    logic [SIZE_W-1:0]       lane_w_q;
    logic [SIZE_W-1:0]       lane_h_q;

    logic [TIMER_W-1:0]      tick_inc;
    logic [TIMER_W:0]        adv_sum;
    logic [TIMER_W-1:0]      adv_sat;
    logic [SIZE_W-1:0]       w_gap;
    logic [SIZE_W-1:0]       h_gap;
    logic [TIMER_W-1:0]      shrink_left;

    ghs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign cfg_ready = 1'b1;
    assign cmd_stall = (state_reg != S_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign commit    = (state_reg == S_DONE) && (!res_valid_reg || !res_stall);

    // classify the item against the present timer
    assign in_grow_hold = (tick_reg < TIMER_W'(cfg.grow_hold));
    assign shrink_left  = cfg.total - tick_reg;

    always_comb
    begin
        op_next = OP_NONE;
        unique case (cmd.mode)
            MODE_START:
            begin
                op_next = OP_START;
            end
            MODE_TICK:
            begin
                if (running_reg)
                begin
                    op_next = (tick_reg >= cfg.total) ? OP_STOP : OP_TICK;
                end
            end
            MODE_ADVANCE:
            begin
                if (running_reg)
                begin
                    op_next = OP_ADVANCE;
                end
            end
            default:
            begin
                op_next = OP_NONE;
            end
        endcase
    end

    // lane operands: min(t, grow) over grow, or remaining shrink ticks over shrink
    always_comb
    begin
        if (in_grow_hold)
        begin
            lane_div   = cfg.grow;
            lane_scale = (tick_reg < TIMER_W'(cfg.grow)) ? tick_reg[TICKS_W-1:0] : cfg.grow;
        end
        else
        begin
            lane_div   = cfg.shrink;
            lane_scale = shrink_left[TICKS_W-1:0];
        end
    end

    assign lane_start = accept && (op_next == OP_TICK);

    ghs_muldiv u_lane_w (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (lane_start),
        .scale    (lane_scale),
        .divisor  (lane_div),
        .full     (cfg.full_width),
        .done     (lane_w_done),
        .quotient (lane_w_q)
    );

    ghs_muldiv u_lane_h (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (lane_start),
        .scale    (lane_scale),
        .divisor  (lane_div),
        .full     (cfg.full_height),
        .done     (lane_h_done),
        .quotient (lane_h_q)
    );

    // new state at the end of an item
    assign tick_inc = tick_reg + TIMER_W'(1);
    assign adv_sum  = {1'b0, tick_reg} + (TIMER_W + 1)'(amount_reg);
    assign adv_sat  = adv_sum[TIMER_W] ? TIMER_MAX : adv_sum[TIMER_W-1:0];
    assign w_gap    = cfg.full_width - lane_w_q;
    assign h_gap    = cfg.full_height - lane_h_q;

    always_comb
    begin
        tick_next    = tick_reg;
        running_next = running_reg;
        blank_next   = blank_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        unique case (op_reg)
            OP_START:
            begin
                tick_next    = '0;
                running_next = 1'b1;
                blank_next   = 1'b0;
                width_next   = '0;
                height_next  = '0;
                x_next       = cfg.origin_x;
                y_next       = cfg.origin_y;
            end
            OP_STOP:
            begin
                tick_next    = '0;
                running_next = 1'b0;
            end
            OP_TICK:
            begin
                width_next  = lane_w_q;
                height_next = lane_h_q;
                x_next      = cfg.origin_x + POS_W'(w_gap >> 1);
                y_next      = cfg.origin_y + POS_W'(h_gap >> 1);
                if (blink_upd_reg)
                begin
                    blank_next = blink_val_reg;
                end
                if (tick_inc >= cfg.total)
                begin
                    tick_next    = '0;
                    running_next = 1'b0;
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            OP_ADVANCE:
            begin
                if (adv_sat >= cfg.total)
                begin
                    tick_next    = '0;
                    running_next = 1'b0;
                end
                else
                begin
                    tick_next = adv_sat;
                end
            end
            default:
            begin
                tick_next = tick_reg;
            end
        endcase
    end

    // sequencer, timer state and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_NONE;
            res_valid_reg <= 1'b0;
            tick_reg      <= '0;
            running_reg   <= 1'b0;
            blank_reg     <= 1'b0;
            width_reg     <= '0;
            height_reg    <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
        end
        else
        begin
            if (res_valid_reg && !res_stall && !commit)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg    <= op_next;
                        state_reg <= (op_next == OP_TICK) ? S_CALC : S_DONE;
                    end
                end
                S_CALC:
                begin
                    if (lane_w_done)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (commit)
                    begin
                        state_reg     <= S_IDLE;
                        res_valid_reg <= 1'b1;
                        tick_reg      <= tick_next;
                        running_reg   <= running_next;
                        blank_reg     <= blank_next;
                        width_reg     <= width_next;
                        height_reg    <= height_next;
                        x_reg         <= x_next;
                        y_reg         <= y_next;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // item payload and result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            amount_reg    <= cmd.advance_amount;
            blink_upd_reg <= in_grow_hold && cfg.blink && (tick_reg > TIMER_W'(cfg.grow));
            blink_val_reg <= tick_reg[2];
        end
        if (commit)
        begin
            res_reg.out_width   <= width_next;
            res_reg.out_height  <= height_next;
            res_reg.out_x       <= x_next;
            res_reg.out_y       <= y_next;
            res_reg.hidden      <= blank_next;
            res_reg.active      <= running_next;
            res_reg.timer_value <= running_next ? tick_next : '0;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    // a stopped overlay always holds a cleared timer
    a_stopped_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> (tick_reg == '0))
        else $error("timer not cleared while stopped");

    // both geometry lanes finish together
    a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        lane_w_done == lane_h_done)
        else $error("geometry lanes out of step");

    // lanes only report while a tick item is being computed
    a_lane_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        lane_w_done |-> (state_reg == S_CALC) && (op_reg == OP_TICK))
        else $error("lane finished outside a tick item");

    // a result is only written when the output register is free or draining
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_stall) |=> ($stable(res_reg) && res_valid_reg))
        else $error("stalled result overwritten");
`endif

endmodule
